### src/ida_pkg.sv
package ida_pkg;

  // Width used for elaboration-time arithmetic on powers of ten.
  localparam int IDA_CALC_W = 72;

  // Default width of the converted integer.
  localparam int IDA_VALUE_WIDTH = 32;

  // ASCII codes of the characters the block emits.
  localparam logic [5:0] IDA_CHAR_MINUS = 6'd45;
  localparam logic [5:0] IDA_CHAR_ZERO  = 6'd48;

  // Control handed from the sequencer to the compare-subtract datapath.
  typedef struct packed {
    logic       load;     // Capture the magnitude of a new value.
    logic       step;     // Run one compare-subtract step.
    logic [1:0] bit_sel;  // Digit weight of this step: 8, 4, 2 or 1 times the power.
  } ida_dp_ctrl_t;

  // Returns 10 to the power k, evaluated at elaboration.
  function automatic logic [IDA_CALC_W-1:0] ida_pow10(input int k);
    logic [IDA_CALC_W-1:0] r;
    r = IDA_CALC_W'(1);
    for (int i = 0; i < k; i++) begin
      r = IDA_CALC_W'(r * IDA_CALC_W'(10));
    end
    return r;
  endfunction

  // Number of decimal digits of the largest magnitude, 2 to the power (w - 1).
  function automatic int ida_num_digits(input int w);
    logic [IDA_CALC_W-1:0] m;
    logic [IDA_CALC_W-1:0] p;
    int                    n;
    m = IDA_CALC_W'(1) << (w - 1);
    p = IDA_CALC_W'(1);
    n = 1;
    for (int i = 0; i < 24; i++) begin
      if (IDA_CALC_W'(p * IDA_CALC_W'(10)) <= m) begin
        p = IDA_CALC_W'(p * IDA_CALC_W'(10));
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

### src/ida_datapath.sv
module ida_datapath import ida_pkg::*; #(
  parameter int VALUE_WIDTH = IDA_VALUE_WIDTH
) (
  input  logic                                  clk_i,
  input  logic signed [VALUE_WIDTH-1:0]         value_i,
  input  logic [((ida_num_digits(VALUE_WIDTH) > 1) ?
                 $clog2(ida_num_digits(VALUE_WIDTH)) : 1)-1:0] idx_i,
  input  ida_dp_ctrl_t                          ctrl_i,
  output logic [3:0]                            digit_o
);

  localparam int MagW = VALUE_WIDTH + 3;
  localparam int NumDigits = ida_num_digits(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] val_u;
  logic [VALUE_WIDTH-1:0] mag;
  logic [MagW-1:0]        pow_tbl [NumDigits];
  logic [MagW-1:0]        weight;
  logic [MagW-1:0]        diff;
  logic                   ge;
  logic [MagW-1:0]        rem_q;
  logic [2:0]             dig_q;

  // Unsigned magnitude; the most negative value maps onto itself correctly.
  assign val_u = value_i;
  assign mag   = val_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - val_u) : val_u;

  // Constant table of powers of ten, one entry per digit position.
  for (genvar gk = 0; gk < NumDigits; gk++) begin : g_pow
    localparam logic [MagW-1:0] Pow = MagW'(ida_pow10(gk));
    assign pow_tbl[gk] = Pow;
  end

  // Shared compare-subtract unit against 8, 4, 2 or 1 times the current power.
  assign weight = pow_tbl[idx_i] << ctrl_i.bit_sel;
  assign ge     = (rem_q >= weight);
  assign diff   = rem_q - weight;

  // Remainder register and the digit bits found so far.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= {3'b000, mag};
      dig_q <= 3'b000;
    end else if (ctrl_i.step) begin
      if (ge) begin
        rem_q <= diff;
      end
      if (ctrl_i.bit_sel == 2'd0) begin
        dig_q <= 3'b000;
      end else begin
        dig_q <= {dig_q[1:0], ge};
      end
    end
  end

  // The full digit is valid during the step with the weight of one.
  assign digit_o = {dig_q, ge};

endmodule

### src/ida_ctrl.sv
module ida_ctrl import ida_pkg::*; #(
  parameter int VALUE_WIDTH = IDA_VALUE_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                neg_i,
  input  logic [3:0]          digit_i,
  output logic                busy_o,
  output logic                strobe_o,
  output logic [5:0]          ascii_char_o,
  output logic                last_o,
  output logic [((ida_num_digits(VALUE_WIDTH) > 1) ?
                 $clog2(ida_num_digits(VALUE_WIDTH)) : 1)-1:0] idx_o,
  output ida_dp_ctrl_t        ctrl_o
);

  localparam int NumDigits = ida_num_digits(VALUE_WIDTH);
  localparam int IdxW = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0]      bit_q, bit_d;
  logic            seen_q, seen_d;
  logic            strobe_q, strobe_d;
  logic [5:0]      char_q, char_d;
  logic            last_q, last_d;
  logic            accept;
  logic            emit;

  assign accept = start_i && (state_q == StIdle);
  assign emit   = (digit_i != 4'd0) || seen_q || (idx_q == '0);

  // Sequencer: four compare-subtract steps per digit, most significant first.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    bit_d    = bit_q;
    seen_d   = seen_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d  = StRun;
          idx_d    = IdxW'(NumDigits - 1);
          bit_d    = 2'd3;
          seen_d   = 1'b0;
          strobe_d = neg_i;
          char_d   = IDA_CHAR_MINUS;
          last_d   = 1'b0;
        end
      end
      StRun: begin
        bit_d = bit_q - 2'd1;
        if (bit_q == 2'd0) begin
          // Leading zeros are dropped, but the units digit always goes out.
          seen_d   = emit;
          strobe_d = emit;
          char_d   = IDA_CHAR_ZERO + {2'b00, digit_i};
          last_d   = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      bit_q    <= 2'd0;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      bit_q    <= bit_d;
      seen_q   <= seen_d;
      strobe_q <= strobe_d;
    end
  end

  // Output character register.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign strobe_o       = strobe_q;
  assign ascii_char_o   = char_q;
  assign last_o         = last_q;
  assign idx_o          = idx_q;
  assign ctrl_o.load    = accept;
  assign ctrl_o.step    = (state_q == StRun);
  assign ctrl_o.bit_sel = bit_q;

`ifndef SYNTHESIS
  // The final character is shown exactly when the sequencer has gone idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy_o) else $error("last character while busy");

  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (strobe_o && last_o)) else $error("idle without last character");

  // The minus sign never ends a number's text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (ascii_char_o == IDA_CHAR_MINUS)) |-> !last_o)
    else $error("minus sign marked last");

  // Every digit found by the compare-subtract steps is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (ascii_char_o != IDA_CHAR_MINUS)) |->
      ((ascii_char_o >= IDA_CHAR_ZERO) && (ascii_char_o <= IDA_CHAR_ZERO + 6'd9)))
    else $error("character out of digit range");

  // An accepted value keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted value not worked on");
`endif

endmodule

### src/int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
//
// Input: a value is transferred on a rising edge with start_i high and busy_o
// low. value_i is a VALUE_WIDTH-bit two's complement integer.
// Output: each character appears on ascii_char_o for one cycle, marked by
// strobe_o; last_o is high on the final digit. The receiver cannot stall:
// characters are produced at fixed times and must be taken as they come.
// A negative value first gives a minus sign in the cycle after the transfer.
// Digits follow most significant first, without leading zeros; zero gives '0'.
// Method: the magnitude is reduced by one shared compare-subtract unit that
// tests 8, 4, 2 and 1 times a power of ten at each of D digit positions, D
// being the digit count of 2^(VALUE_WIDTH-1) (10 at the default width).
// busy_o goes high after the transfer and falls in the cycle the last digit
// shows; the next value may be transferred at the edge that ends that cycle,
// so a new value is not taken before the last one is through.
// Reset clears the sequencer and the strobe; no character is pending after it.
module int_to_decimal_ascii import ida_pkg::*; #(
  parameter int VALUE_WIDTH = IDA_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          strobe_o,
  output logic [5:0]                    ascii_char_o,
  output logic                          last_o
);

  localparam int NumDigits = ida_num_digits(VALUE_WIDTH);
  localparam int IdxW = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  logic [IdxW-1:0] idx;
  ida_dp_ctrl_t    dp_ctrl;
  logic [3:0]      digit;

  // Sequencer and output character register.
  ida_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .neg_i       (value_i[VALUE_WIDTH-1]),
    .digit_i     (digit),
    .busy_o      (busy_o),
    .strobe_o    (strobe_o),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o),
    .idx_o       (idx),
    .ctrl_o      (dp_ctrl)
  );

  // Remainder register and compare-subtract unit.
  ida_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .value_i(value_i),
    .idx_i  (idx),
    .ctrl_i (dp_ctrl),
    .digit_o(digit)
  );

endmodule
